[hw/rtl/hdrse_pkg.sv]
// ----------------------------------------------------------------------------
// hdrse_pkg: shared types and constants for the HDR exposure / sRGB encoder
// Holds the fixed-point formats, the sRGB curve table (built at elaboration)
// and the stage enable bundle passed from the control to the color lanes.
// ----------------------------------------------------------------------------
package hdrse_pkg;

  // Curve table resolution (5..12): table has 2^CURVE_TABLE_BITS + 1 nodes
  localparam int unsigned CURVE_TABLE_BITS = 8;
  localparam int unsigned CURVE_NODES      = (1 << CURVE_TABLE_BITS) + 1;
  // Linear value is Q0.24; low bits below the table index interpolate
  localparam int unsigned LIN_W            = 24;
  localparam int unsigned FRAC_BITS        = LIN_W - CURVE_TABLE_BITS;
  // Curve values are signed Q.20, range about -0.055 .. 1.0
  localparam int unsigned CURVE_FRAC       = 20;
  localparam int unsigned CURVE_W          = 22;
  localparam longint      OFFSET_Q20       = 57672;

  // Linear toe: 12.92 * 255 * L, L below 0.0031308 in Q0.24
  localparam logic [LIN_W-1:0] TOE_LIMIT = 24'd52526;
  localparam logic [15:0]      TOE_MUL   = 16'd32946;
  // floor(w / 10) == (w * 205) >> 11 for w below 1029
  localparam logic [15:0]      DIV10_MUL = 16'd205;
  localparam int unsigned      DIV10_SH  = 11;

  localparam logic [7:0] BYTE_MAX = 8'd255;

  // Register stages from input to output register
  localparam int unsigned NUM_STAGES = 5;

  typedef logic signed [CURVE_W-1:0] curve_arr_t [CURVE_NODES];

  // One load enable per pipeline stage
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
  } stage_en_t;

  // Integer k-th root by bisection, elaboration only
  function automatic logic [63:0] iroot(input logic [63:0] v, input int unsigned k,
                                        input logic [63:0] hi_in);
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    logic [63:0] p;
    int unsigned j;
    lo = 64'd0;
    hi = hi_in;
    while (lo < hi) begin
      mid = (lo + hi + 64'd1) >> 1;
      p = mid;
      for (j = 1; j < k; j++) begin
        p = p * mid;
      end
      if (p <= v) begin
        lo = mid;
      end else begin
        hi = mid - 64'd1;
      end
    end
    return lo;
  endfunction

  // sRGB curve nodes: 1.055 * x^(5/12) - 0.055, x^(1/12) via cbrt, sqrt, sqrt
  function automatic curve_arr_t build_curve();
    curve_arr_t  y;
    logic [63:0] x;
    logic [63:0] c;
    logic [63:0] s;
    logic [63:0] t;
    logic [63:0] p;
    longint      v;
    int unsigned i;
    int unsigned j;
    for (i = 0; i < CURVE_NODES; i++) begin
      x = 64'(i) << (CURVE_FRAC - CURVE_TABLE_BITS);
      c = iroot(x << 40, 3, 64'd1 << 20);
      s = iroot(c << 20, 2, 64'd1 << 20);
      t = iroot(s << 20, 2, 64'd1 << 20);
      p = t;
      for (j = 0; j < 4; j++) begin
        p = (p * t) >> 20;
      end
      v = longint'(p * 64'd1055 / 64'd1000) - OFFSET_Q20;
      y[i] = CURVE_W'(v);
    end
    return y;
  endfunction

  localparam curve_arr_t CURVE_Y = build_curve();

endpackage

[hw/rtl/hdrse_lane.sv]
// ----------------------------------------------------------------------------
// hdrse_lane: one color channel of the exposure / sRGB encode pipeline
// Gain multiply, toe/curve split with table lookup, interpolation, byte
// scaling and clamp. Data registers only; valid tracking lives in the top.
// ----------------------------------------------------------------------------
module hdrse_lane (
  input  logic                  clk,
  input  hdrse_pkg::stage_en_t  en,
  input  logic [31:0]           color,
  input  logic [31:0]           gain,
  output logic [7:0]            byte_o
);
  import hdrse_pkg::*;

  localparam int unsigned IDX_W  = CURVE_TABLE_BITS;
  localparam int unsigned PROD_W = CURVE_W + FRAC_BITS;
  localparam int unsigned SCL_W  = CURVE_W + 8;

  // Stage 1: gain product, Q24.40
  logic [63:0] prod_r;
  logic        neg1_r;

  always_ff @(posedge clk) begin
    if (en.s1) begin
      prod_r <= 64'(color) * 64'(gain);
      neg1_r <= color[31];
    end
  end

  // Stage 2: linear value, range split, table lookup, toe product
  logic [LIN_W-1:0]     lin;
  logic [IDX_W-1:0]     idx;
  logic [IDX_W:0]       idx_hi;
  logic                 neg2_r;
  logic                 sat2_r;
  logic                 toe2_r;
  logic [31:0]          toe_prod_r;
  logic signed [CURVE_W-1:0] y0_2_r;
  logic signed [CURVE_W-1:0] y1_2_r;
  logic [FRAC_BITS-1:0] frac2_r;

  assign lin    = prod_r[LIN_W+15:16];
  assign idx    = lin[LIN_W-1 -: IDX_W];
  assign idx_hi = {1'b0, idx} + (IDX_W+1)'(1);

  always_ff @(posedge clk) begin
    if (en.s2) begin
      neg2_r     <= neg1_r;
      sat2_r     <= (prod_r[63:LIN_W+16] != '0);
      toe2_r     <= (lin < TOE_LIMIT);
      toe_prod_r <= 32'(lin[15:0]) * 32'(TOE_MUL);
      y0_2_r     <= CURVE_Y[{1'b0, idx}];
      y1_2_r     <= CURVE_Y[idx_hi];
      frac2_r    <= lin[FRAC_BITS-1:0];
    end
  end

  // Stage 3: interpolation product, toe divide by ten
  logic [CURVE_W-1:0]        diff;
  logic [15:0]               div10_full;
  logic                      neg3_r;
  logic                      sat3_r;
  logic                      toe3_r;
  logic [7:0]                toe_byte3_r;
  logic signed [CURVE_W-1:0] y0_3_r;
  logic [PROD_W-1:0]         fprod_r;

  // Curve is monotonic, so the node step is never negative
  assign diff       = y1_2_r - y0_2_r;
  assign div10_full = 16'(toe_prod_r[31:24]) * DIV10_MUL;

  always_ff @(posedge clk) begin
    if (en.s3) begin
      neg3_r      <= neg2_r;
      sat3_r      <= sat2_r;
      toe3_r      <= toe2_r;
      toe_byte3_r <= 8'(div10_full >> DIV10_SH);
      y0_3_r      <= y0_2_r;
      fprod_r     <= PROD_W'(diff) * PROD_W'(frac2_r);
    end
  end

  // Stage 4: interpolated curve value
  logic signed [CURVE_W:0] y_nxt;
  logic signed [CURVE_W:0] y4_r;
  logic                    neg4_r;
  logic                    sat4_r;
  logic                    toe4_r;
  logic [7:0]              toe_byte4_r;

  assign y_nxt = {y0_3_r[CURVE_W-1], y0_3_r} +
                 $signed({1'b0, fprod_r[PROD_W-1:FRAC_BITS]});

  always_ff @(posedge clk) begin
    if (en.s4) begin
      neg4_r      <= neg3_r;
      sat4_r      <= sat3_r;
      toe4_r      <= toe3_r;
      toe_byte4_r <= toe_byte3_r;
      y4_r        <= y_nxt;
    end
  end

  // Stage 5: scale by 255, truncate, clamp, select
  logic [SCL_W-1:0]             scaled;
  logic [SCL_W-CURVE_FRAC-1:0]  scaled_hi;
  logic [7:0]                   byte_nxt;
  logic [7:0]                   byte_r;

  assign scaled    = SCL_W'(y4_r[CURVE_W-1:0]) * SCL_W'(BYTE_MAX);
  assign scaled_hi = scaled[SCL_W-1:CURVE_FRAC];

  always_comb begin
    if (neg4_r) begin
      byte_nxt = '0;
    end else if (sat4_r) begin
      byte_nxt = BYTE_MAX;
    end else if (toe4_r) begin
      byte_nxt = toe_byte4_r;
    end else if (y4_r <= 0) begin
      byte_nxt = '0;
    end else if (scaled_hi > (SCL_W-CURVE_FRAC)'(BYTE_MAX)) begin
      byte_nxt = BYTE_MAX;
    end else begin
      byte_nxt = scaled_hi[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en.s5) begin
      byte_r <= byte_nxt;
    end
  end

  assign byte_o = byte_r;

endmodule

[hw/rtl/hdr_exposure_srgb_encode.sv]
// ----------------------------------------------------------------------------
// hdr_exposure_srgb_encode: linear HDR RGBA to 8-bit sRGB RGBA
// Colors are scaled by the exposure gain and sRGB encoded through a curve
// table with linear interpolation; alpha is scaled by 255 and clamped.
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+-------------------------------
//  in_     | input     | in_valid / in_stall | red/green/blue/alpha, Q16.16
//  out_    | output    | out_valid/out_stall | red/green/blue/alpha bytes
//  cfg_    | input     | cfg_valid/cfg_ready | exposure gain, Q8.24
//
//  One item per cycle sustained while out_stall is low, through the register stages
//  (gain multiply, table lookup, interpolation multiply, curve sum, output).
//  Each stage loads when it is empty or the stage after it moves, so bubbles
//  fill while the output is stalled and nothing is lost or repeated.
//  rst_n (synchronous) clears the valid bits and loads the gain with 1.0.
//  cfg_ready always high; the user writes the gain between items, unchecked.
// ----------------------------------------------------------------------------
module hdr_exposure_srgb_encode (
  input  logic        clk,
  input  logic        rst_n,
  // input items
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_red_in,
  input  logic [31:0] in_green_in,
  input  logic [31:0] in_blue_in,
  input  logic [31:0] in_alpha_in,
  // result items
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_red_out,
  output logic [7:0]  out_green_out,
  output logic [7:0]  out_blue_out,
  output logic [7:0]  out_alpha_out,
  // exposure gain register
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_exposure_gain
);
  import hdrse_pkg::*;

  localparam logic [31:0] GAIN_RESET = 32'h0100_0000;

  // Gain register
  logic [31:0] gain_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= GAIN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      gain_r <= cfg_exposure_gain;
    end
  end

  // Stage valid bits and ready chain
  logic [NUM_STAGES-1:0] vld_r;
  logic [NUM_STAGES-1:0] vld_nxt;
  logic [NUM_STAGES-1:0] rdy;
  logic [NUM_STAGES-1:0] feed;
  stage_en_t             en;

  assign feed = {vld_r[NUM_STAGES-2:0], in_valid};

  always_comb begin
    rdy[NUM_STAGES-1] = !vld_r[NUM_STAGES-1] || !out_stall;
    for (int i = NUM_STAGES - 2; i >= 0; i--) begin
      rdy[i] = !vld_r[i] || rdy[i+1];
    end
    for (int i = 0; i < NUM_STAGES; i++) begin
      vld_nxt[i] = rdy[i] ? feed[i] : vld_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign en = '{s1: rdy[0], s2: rdy[1], s3: rdy[2], s4: rdy[3], s5: rdy[4]};

  assign in_stall  = !rdy[0];
  assign out_valid = vld_r[NUM_STAGES-1];

  // Color lanes
  hdrse_lane u_lane_red (
    .clk    (clk),
    .en     (en),
    .color  (in_red_in),
    .gain   (gain_r),
    .byte_o (out_red_out)
  );

  hdrse_lane u_lane_green (
    .clk    (clk),
    .en     (en),
    .color  (in_green_in),
    .gain   (gain_r),
    .byte_o (out_green_out)
  );

  hdrse_lane u_lane_blue (
    .clk    (clk),
    .en     (en),
    .color  (in_blue_in),
    .gain   (gain_r),
    .byte_o (out_blue_out)
  );

  // Alpha: 255 * a, truncated, clamped; computed at entry and carried along
  logic [39:0] alpha_scaled;
  logic [23:0] alpha_hi;
  logic [7:0]  alpha_byte;
  logic [7:0]  alpha_r [NUM_STAGES];

  assign alpha_scaled = (40'(in_alpha_in) << 8) - 40'(in_alpha_in);
  assign alpha_hi     = alpha_scaled[39:16];

  always_comb begin
    if (in_alpha_in[31] || (in_alpha_in == '0)) begin
      alpha_byte = '0;
    end else if (alpha_hi > 24'(BYTE_MAX)) begin
      alpha_byte = BYTE_MAX;
    end else begin
      alpha_byte = alpha_hi[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      alpha_r[0] <= alpha_byte;
    end
    for (int i = 1; i < NUM_STAGES; i++) begin
      if (rdy[i]) begin
        alpha_r[i] <= alpha_r[i-1];
      end
    end
  end

  assign out_alpha_out = alpha_r[NUM_STAGES-1];

  // Checks
  logic in_acc;
  logic out_acc;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  // input is held off only when every stage holds an item
  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (&vld_r))
    else $error("input stalled with an empty stage");

  // items in flight change only by accepts and deliveries
  a_item_count: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(vld_nxt) == $countones(vld_r) + int'(in_acc) - int'(out_acc))
    else $error("item lost or duplicated in pipeline");

  // reset leaves the pipeline empty
  a_reset_empty: assert property (@(posedge clk)
    (rst_n && $past(!rst_n)) |-> (vld_r == '0))
    else $error("valid bits not cleared by reset");

endmodule

[tb/hdr_exposure_srgb_encode_test.sv]
// ----------------------------------------------------------------------------
// hdr_exposure_srgb_encode_test: self-checking bench for the sRGB encoder
// Drives linear Q16.16 pixels through the exposure / sRGB encoder under
// several gain settings and random idling on both sides. A scoreboard
// predicts each output byte in plain integer math and checks the results
// in order.
// ----------------------------------------------------------------------------
module hdr_exposure_srgb_encode_test;

  localparam int          TABLE_BITS   = hdrse_pkg::CURVE_TABLE_BITS;
  localparam int          FRAC_W       = 24 - TABLE_BITS;
  localparam int          NODE_COUNT   = (1 << TABLE_BITS) + 1;
  localparam int          LATENCY      = hdrse_pkg::NUM_STAGES;
  localparam logic [31:0] UNITY_GAIN   = 32'h0100_0000;
  localparam logic [63:0] TOE_END      = 64'd52526;
  localparam longint      CURVE_OFFSET = 57672;
  localparam int          PHASE_COUNT  = 9;
  localparam int          PHASE_ITEMS  = 60;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } rgba_bytes_t;

  // Byte predictor plus the queue of bytes still owed by the encoder
  class encode_scoreboard;
    longint      curve_node [NODE_COUNT];
    logic [31:0] gain;
    rgba_bytes_t pending_bytes [$];
    int          mismatches;

    function new();
      logic [63:0] x;
      logic [63:0] c;
      logic [63:0] s;
      logic [63:0] t;
      logic [63:0] p;
      gain = UNITY_GAIN;
      mismatches = 0;
      // x^(1/12) by cube root and two square roots, then raised to the 5th
      for (int i = 0; i < NODE_COUNT; i++) begin
        x = 64'(i) << (20 - TABLE_BITS);
        c = floor_root(x << 40, 3);
        s = floor_root(c << 20, 2);
        t = floor_root(s << 20, 2);
        p = t;
        repeat (4) p = (p * t) >> 20;
        curve_node[i] = longint'(p * 64'd1055 / 64'd1000) - CURVE_OFFSET;
      end
    endfunction

    // Greedy bit-by-bit integer root, results fit in 21 bits
    static function logic [63:0] floor_root(logic [63:0] v, int unsigned k);
      logic [63:0] r;
      logic [63:0] cand;
      logic [63:0] pw;
      r = 64'd0;
      for (int b = 20; b >= 0; b--) begin
        cand = r | (64'd1 << b);
        pw = cand;
        for (int j = 1; j < k; j++) pw = pw * cand;
        if (pw <= v) r = cand;
      end
      return r;
    endfunction

    function logic [7:0] encode_color(logic [31:0] c);
      logic [63:0] prod;
      logic [63:0] lin;
      logic [63:0] idx;
      logic [63:0] frac;
      logic [63:0] slope;
      longint      y;
      if (c[31] || c == 32'd0 || gain == 32'd0) return 8'd0;
      prod = 64'(c) * 64'(gain);
      if (prod >= (64'd1 << 40)) return 8'd255;
      lin = prod >> 16;
      // linear toe: 12.92 * 255 * L
      if (lin < TOE_END) return 8'((lin * 64'd32946) / (64'd10 << 24));
      idx = lin >> FRAC_W;
      frac = lin & ((64'd1 << FRAC_W) - 64'd1);
      slope = 64'(curve_node[idx + 1] - curve_node[idx]);
      y = curve_node[idx] + longint'((slope * frac) >> FRAC_W);
      if (y <= 0) return 8'd0;
      lin = (64'(y) * 64'd255) >> 20;
      return (lin > 64'd255) ? 8'd255 : 8'(lin);
    endfunction

    function logic [7:0] encode_alpha(logic [31:0] a);
      logic [63:0] v;
      if (a[31] || a == 32'd0) return 8'd0;
      v = (64'(a) * 64'd255) >> 16;
      return (v > 64'd255) ? 8'd255 : 8'(v);
    endfunction

    function void note_pixel(logic [31:0] r, logic [31:0] g, logic [31:0] b,
                             logic [31:0] a);
      rgba_bytes_t want;
      want.red   = encode_color(r);
      want.green = encode_color(g);
      want.blue  = encode_color(b);
      want.alpha = encode_alpha(a);
      pending_bytes.push_back(want);
    endfunction

    task report_mismatch(string what, logic [31:0] want, logic [31:0] got);
      mismatches++;
      $display("mismatch %s: expected %0d, got %0d at %0t", what, want, got, $time);
    endtask

    task check_bytes(rgba_bytes_t got);
      rgba_bytes_t want;
      if (pending_bytes.size() == 0) begin
        report_mismatch("pixel with none outstanding", 0, got);
        return;
      end
      want = pending_bytes.pop_front();
      if (got.red !== want.red) report_mismatch("red", want.red, got.red);
      if (got.green !== want.green) report_mismatch("green", want.green, got.green);
      if (got.blue !== want.blue) report_mismatch("blue", want.blue, got.blue);
      if (got.alpha !== want.alpha) report_mismatch("alpha", want.alpha, got.alpha);
    endtask

    function int pending();
      return pending_bytes.size();
    endfunction

    task flush_leftovers();
      rgba_bytes_t want;
      while (pending_bytes.size() != 0) begin
        want = pending_bytes.pop_front();
        report_mismatch("pixel never delivered", want, 0);
      end
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] in_red_in = 32'd0;
  logic [31:0] in_green_in = 32'd0;
  logic [31:0] in_blue_in = 32'd0;
  logic [31:0] in_alpha_in = 32'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_red_out;
  logic [7:0]  out_green_out;
  logic [7:0]  out_blue_out;
  logic [7:0]  out_alpha_out;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_exposure_gain = 32'd0;

  encode_scoreboard board = new();

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_request = 0;

  hdr_exposure_srgb_encode DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_red_in        (in_red_in),
    .in_green_in      (in_green_in),
    .in_blue_in       (in_blue_in),
    .in_alpha_in      (in_alpha_in),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_red_out      (out_red_out),
    .out_green_out    (out_green_out),
    .out_blue_out     (out_blue_out),
    .out_alpha_out    (out_alpha_out),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_exposure_gain(cfg_exposure_gain)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Hard stop in case the pipeline hangs
  initial begin
    #(12 * 300000);
    $display("RESULT: ERROR");
    $finish;
  end

  // Receiver: random stalls, or a long hold-off when one is requested
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall == 1'b0)
      board.check_bytes({out_red_out, out_green_out, out_blue_out, out_alpha_out});
  end

  // Color mostly inside the unsaturated range for the current gain,
  // spread over many octaves so the toe and the curve both get hit
  function automatic logic [31:0] pick_color(logic [31:0] g);
    int unsigned sel;
    logic [63:0] lim;
    logic [63:0] v;
    sel = $urandom_range(99);
    if (sel < 8) return $urandom;
    if (sel < 11) return 32'd0;
    if (sel < 14) return 32'h8000_0000 | $urandom;
    if (g == 32'd0) lim = 64'h7FFF_FFFF;
    else lim = ((64'd1 << 40) - 64'd1) / 64'(g);
    if (lim > 64'h7FFF_FFFF) lim = 64'h7FFF_FFFF;
    // right at the saturation boundary
    if (sel < 20) return 32'(lim + 64'($urandom_range(3)));
    v = ({$urandom, $urandom} % (lim + 64'd1)) >> $urandom_range(22);
    return v[31:0];
  endfunction

  function automatic logic [31:0] pick_alpha();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 10) return $urandom;
    if (sel < 18) return 32'h0001_0000 + $urandom_range(512) - 256;
    return $urandom_range(32'h0001_2000);
  endfunction

  function automatic logic [31:0] phase_gain(int ph);
    case (ph)
      1:       return 32'h0400_0000;
      2:       return 32'h0040_0000;
      3:       return 32'hFFFF_FFFF;
      4:       return 32'h0000_0000;
      5:       return 32'h0000_0001;
      6:       return 32'h1 << $urandom_range(31);
      7:       return $urandom;
      default: return UNITY_GAIN;
    endcase
  endfunction

  task automatic send_pixel(input logic [31:0] r, input logic [31:0] g,
                            input logic [31:0] b, input logic [31:0] a);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_red_in   <= r;
    in_green_in <= g;
    in_blue_in  <= b;
    in_alpha_in <= a;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    board.note_pixel(r, g, b, a);
  endtask

  task automatic send_random_pixel();
    send_pixel(pick_color(board.gain), pick_color(board.gain),
               pick_color(board.gain), pick_alpha());
  endtask

  // Stop offering and wait for every outstanding pixel
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
  endtask

  task automatic write_gain(input logic [31:0] g);
    drain_results();
    repeat (LATENCY) @(posedge clk);
    @(negedge clk);
    cfg_valid         <= 1'b1;
    cfg_exposure_gain <= g;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    board.gain = g;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Main sequence
  initial begin
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 26;
    recv_idle_pct = 48;

    // directed pixels at the reset gain of 1.0
    send_pixel(32'd0, 32'd0, 32'd0, 32'd0);
    send_pixel(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
    send_pixel(32'h8000_0000, 32'h7FFF_FFFF, 32'd1, 32'h8000_0000);
    send_pixel(32'd1, 32'd205, 32'd206, 32'd1);           // toe and its edge
    send_pixel(32'h0000_FFFF, 32'h0001_0000, 32'h0000_8000, 32'h0001_0000);
    send_pixel(32'h0001_0001, 32'h0000_0100, 32'h0000_0101, 32'h0000_FFFF);
    send_pixel(32'h0000_00CC, 32'h0000_00CD, 32'h0000_00CE, 32'h0001_0101);
    send_pixel(32'h0000_0FFF, 32'h0000_1000, 32'h0000_7FFF, 32'h0001_0100);
    send_pixel(32'hFFFF_0000, 32'h0000_0002, 32'h0000_FF00, 32'hFFFF_FFFF);
    send_pixel(32'h0000_0400, 32'h0000_4000, 32'h0000_C000, 32'h0000_0101);
    send_pixel(32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_5555, 32'h0000_AAAA);
    send_pixel(32'h0000_00FF, 32'h0000_0001, 32'h0000_FFFE, 32'h0000_0100);

    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      if (ph == 3) begin
        send_idle_pct = 48;
        recv_idle_pct = 26;
      end else if (ph == 6) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (ph > 0) write_gain(phase_gain(ph));
      if (ph == 2) begin
        // long receiver hold-off while the sender keeps pushing
        drain_results();
        hold_request = 80;
        send_idle_pct = 0;
        repeat (40) send_random_pixel();
        send_idle_pct = 26;
      end
      repeat (PHASE_ITEMS) send_random_pixel();
    end

    drain_results();
    repeat (LATENCY + 4) @(posedge clk);
    board.flush_leftovers();
    if (board.mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[hdr_exposure_srgb_encode.f]
hw/rtl/hdrse_pkg.sv
hw/rtl/hdrse_lane.sv
hw/rtl/hdr_exposure_srgb_encode.sv
tb/hdr_exposure_srgb_encode_test.sv
